// ===== hdl/coef_pkg.sv =====
// Package for the clock offset EMA filter: field widths, result modes and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
package coef_pkg;

    localparam int MS_W     = 40;                   // millisecond time fields
    localparam int OFS_W    = MS_W + 1;             // signed offset
    localparam int FAC_W    = 8;                    // filter factor
    localparam int DIV_W    = FAC_W + 1;            // factor + 1, up to 256
    localparam int REM_W    = FAC_W + 1;            // signed remainder
    localparam int SUM_W    = OFS_W + DIV_W;        // signed weighted sum
    localparam int MAG_W    = SUM_W - 1;            // magnitude of the sum
    localparam int CNT_W    = 6;                    // divider step counter
    localparam int IN_W     = 2 * MS_W;             // s_tdata width
    localparam int OUT_RAW  = 1 + MS_W + OFS_W;     // packed result fields
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
    localparam int ADDR_W   = 3;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

    localparam logic [ADDR_W-1:0] REG_FILTER_FACTOR = 3'd0;

    localparam logic [FAC_W-1:0] FACTOR_RESET = 8'd7;

    // What the commit does with the current item
    localparam logic [1:0] MODE_SET  = 2'd0;   // ask to set the local clock
    localparam logic [1:0] MODE_LOAD = 2'd1;   // load the raw offset
    localparam logic [1:0] MODE_FILT = 2'd2;   // load the filtered offset

    localparam logic ACTION_SET    = 1'b0;
    localparam logic ACTION_FILTER = 1'b1;

    typedef struct packed {
        logic       latch;      // input transfer: capture the sample
        logic       mul;        // offset times factor
        logic       add;        // add new offset and remainder
        logic       abso;       // take magnitude, load divider
        logic       step;       // one restoring divider step
        logic       commit;     // update state, load output register
        logic [1:0] mode;
    } coef_cmd_t;

    typedef struct packed {
        logic first_samples;    // fewer than two samples seen
        logic offset_zero;      // stored offset is zero
        logic div_last;         // final divider step
        logic out_busy;         // output register full and stalled
    } coef_sts_t;

endpackage

// ===== hdl/coef_ctrl.sv =====
// Controller for the clock offset EMA filter: sequences multiply, add,
// magnitude and serial divide, and gates the commit on the output register.
// Depends on coef_pkg.
module coef_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  coef_pkg::coef_sts_t sts,
    output coef_pkg::coef_cmd_t cmd
);
    import coef_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.mode   = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    priority if (sts.first_samples)
                    begin
                        mode_next  = MODE_SET;
                        state_next = ST_DONE;
                    end
                    else if (sts.offset_zero)
                    begin
                        mode_next  = MODE_LOAD;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mode_next  = MODE_FILT;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abso   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_SET;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.out_busy)
        else $error("commit while output register stalled");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && sts.div_last |=> state_reg == ST_DONE)
        else $error("divider did not finish");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("ready held after input transfer");

endmodule

// ===== hdl/coef_dp.sv =====
// Datapath for the clock offset EMA filter: sample registers, multiplier,
// restoring serial divider, filter state and the output register.
// Depends on coef_pkg.
module coef_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [coef_pkg::IN_W-1:0]      s_tdata,
    input  logic [coef_pkg::FAC_W-1:0]     factor,
    input  coef_pkg::coef_cmd_t            cmd,
    output coef_pkg::coef_sts_t            sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [coef_pkg::OUT_W-1:0]     m_tdata
);
    import coef_pkg::*;

    logic [MS_W-1:0]         ref_reg;
    logic signed [OFS_W-1:0] fresh_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        div_q_reg;
    logic [REM_W-1:0]        div_r_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [OFS_W-1:0] off_reg;
    logic signed [REM_W-1:0] rem_reg;
    logic [1:0]              count_reg;

    logic                    out_valid_reg;
    logic                    out_action_reg;
    logic [MS_W-1:0]         out_clock_reg;
    logic signed [OFS_W-1:0] out_offset_reg;

    logic [DIV_W-1:0]        divisor;
    logic [REM_W:0]          shifted;
    logic                    fits;
    logic [OFS_W-1:0]        q_mag;
    logic signed [OFS_W-1:0] q_signed;
    logic signed [REM_W-1:0] r_signed;
    logic [MAG_W-1:0]        sum_mag;

    assign divisor  = DIV_W'(factor) + DIV_W'(1);
    assign shifted  = {div_r_reg, div_q_reg[MAG_W-1]};
    assign fits     = shifted >= {1'b0, divisor};
    assign q_mag    = div_q_reg[OFS_W-1:0];
    assign q_signed = neg_reg ? $signed(~q_mag + OFS_W'(1)) : $signed(q_mag);
    assign r_signed = neg_reg ? $signed(~div_r_reg + REM_W'(1)) : $signed(div_r_reg);
    assign sum_mag  = sum_reg[SUM_W-1] ? MAG_W'(~sum_reg + SUM_W'(1)) : MAG_W'(sum_reg);

    assign sts.first_samples = !count_reg[1];
    assign sts.offset_zero   = (off_reg == '0);
    assign sts.div_last      = (cnt_reg == DIV_LAST);
    assign sts.out_busy      = out_valid_reg && !m_tready;

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ref_reg   <= s_tdata[MS_W-1:0];
            fresh_reg <= $signed({1'b0, s_tdata[MS_W-1:0]})
                       - $signed({1'b0, s_tdata[IN_W-1:MS_W]});
        end
        if (cmd.mul)
            prod_reg <= SUM_W'(off_reg) * SUM_W'($signed({1'b0, factor}));
        if (cmd.add)
            sum_reg <= prod_reg + SUM_W'(fresh_reg) + SUM_W'(rem_reg);
        if (cmd.abso)
        begin
            neg_reg   <= sum_reg[SUM_W-1];
            div_q_reg <= sum_mag;
            div_r_reg <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.step)
        begin
            div_r_reg <= fits ? REM_W'(shifted - {1'b0, divisor}) : shifted[REM_W-1:0];
            div_q_reg <= {div_q_reg[MAG_W-2:0], fits};
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
        if (cmd.commit)
        begin
            unique case (cmd.mode)
                MODE_SET:
                begin
                    out_action_reg <= ACTION_SET;
                    out_clock_reg  <= ref_reg;
                    out_offset_reg <= off_reg;
                end
                MODE_LOAD:
                begin
                    out_action_reg <= ACTION_FILTER;
                    out_clock_reg  <= '0;
                    out_offset_reg <= fresh_reg;
                end
                default:
                begin
                    out_action_reg <= ACTION_FILTER;
                    out_clock_reg  <= '0;
                    out_offset_reg <= q_signed;
                end
            endcase
        end
    end

    // filter state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg       <= '0;
            rem_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                unique case (cmd.mode)
                    MODE_SET:  count_reg <= count_reg + 2'd1;
                    MODE_LOAD: off_reg   <= fresh_reg;
                    default:
                    begin
                        off_reg <= q_signed;
                        rem_reg <= r_signed;
                    end
                endcase
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-OUT_RAW){1'b0}}, out_offset_reg, out_clock_reg,
                       out_action_reg};

    a_rise_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result appeared without commit");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("sample count passed saturation");

endmodule

// ===== hdl/clock_offset_ema_filter.sv =====
// Top level of the clock offset EMA filter: APB register for the filter
// factor, controller and datapath. Depends on coef_pkg, coef_ctrl, coef_dp.
//
// Usage: each transfer on the s_ channel carries one reference time sample
// (reference and local clock, milliseconds). Each sample yields exactly one
// result transfer on the m_ channel: action, clock value and current offset.
// The first two samples after reset return action 0 (set the local clock to
// clock_value). Later samples load or filter the offset, reference minus
// local, and return action 1.
// Clock-set samples and the direct load while the stored offset is zero go
// from the input transfer straight to the commit state. A filtered sample
// passes through multiply, add, magnitude, 49 restoring divider steps by
// factor plus one, and commit. The block takes one sample at a time:
// s_tready stays low from the input transfer until the commit.
// Reset clears the offset, remainder and sample count and sets the factor
// to 7. A stalled receiver holds the result in the output register and
// the block finishes the next sample only up to its commit, where it waits.
// Write filter_factor at byte address 0 only while the block is idle.
module clock_offset_ema_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: [39:0] reference_ms, [79:40] local_ms
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [coef_pkg::IN_W-1:0]     s_tdata,
    // m_tdata: [0] action, [40:1] clock_value, [81:41] offset_ms, [87:82] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [coef_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [coef_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import coef_pkg::*;

    logic [FAC_W-1:0] factor_reg;
    logic             reg_hit;
    coef_cmd_t        cmd;
    coef_sts_t        sts;

    assign pready  = 1'b1;
    // byte lanes ignored: only the word address selects the register
    assign reg_hit = (paddr[ADDR_W-1] == REG_FILTER_FACTOR[ADDR_W-1]);
    assign prdata  = reg_hit ? {{(32-FAC_W){1'b0}}, factor_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            factor_reg <= pwdata[FAC_W-1:0];
    end

    coef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    coef_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .factor   (factor_reg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
